[rtl/csjq_pkg.sv]
// csjq_pkg: shared types and command codes for the job queue
// no dependencies
`default_nettype none
package csjq_pkg;
  localparam logic [2:0] CMD_POST_TAIL  = 3'd0;
  localparam logic [2:0] CMD_POST_HEAD  = 3'd1;
  localparam logic [2:0] CMD_POST_KEYED = 3'd2;
  localparam logic [2:0] CMD_CANCEL     = 3'd3;
  localparam logic [2:0] CMD_BARRIER    = 3'd4;
  localparam logic [2:0] CMD_POP        = 3'd5;
  localparam logic [2:0] CMD_SHUTDOWN   = 3'd6;

  // controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the incoming word
    logic replace;   // keyed removal step
    logic shed;      // budget shed step
    logic finish;    // insert / pop / cancel and result
  } ctl_t;
endpackage
`default_nettype wire

[rtl/coalescing_shedding_job_queue.sv]
// coalescing_shedding_job_queue: ordered job queue with key coalescing and shedding
// a captured word runs the replace, shed and finish steps; out_valid rises together with its result registers
// a new word is taken only in idle, once the last one has run its finish step; busy is high until then
// reset: synchronous active-low rst_n empties the queue, clears shutdown and budget
// the receiver cannot stall; each result shows for one cycle with out_valid
// depends on csjq_pkg, csjq_ctrl, csjq_datapath
`default_nettype none
module coalescing_shedding_job_queue #(
  parameter int QUEUE_SLOTS = 16,
  parameter int TAG_BITS    = 16,
  parameter int KEY_BITS    = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [2:0]          in_cmd,
  input  wire logic [TAG_BITS-1:0] in_job_tag,
  input  wire logic [KEY_BITS-1:0] in_key_id,
  input  wire logic                in_is_droppable,
  input  wire logic                in_cancel_first,
  input  wire logic                cfg_we,
  input  wire logic [4:0]          cfg_wdata,
  output logic                     out_valid,
  output logic                     out_accepted,
  output logic                     out_rejected_full,
  output logic                     out_shed_valid,
  output logic [TAG_BITS-1:0]      out_shed_tag,
  output logic                     out_replaced_valid,
  output logic [TAG_BITS-1:0]      out_replaced_tag,
  output logic                     out_popped_valid,
  output logic [TAG_BITS-1:0]      out_popped_tag,
  output logic                     out_popped_runs,
  output logic [1:0]               out_completions,
  output logic [4:0]               out_queue_depth
);
  // sequencer steps travel to the datapath as one struct
  csjq_pkg::ctl_t ctl;

  csjq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .ctl(ctl)
  );

  // slots, parallel key/shed compares and shift compaction
  csjq_datapath #(
    .QUEUE_SLOTS(QUEUE_SLOTS), .TAG_BITS(TAG_BITS), .KEY_BITS(KEY_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .in_cmd(in_cmd), .in_job_tag(in_job_tag), .in_key_id(in_key_id),
    .in_is_droppable(in_is_droppable), .in_cancel_first(in_cancel_first),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_accepted(out_accepted), .out_rejected_full(out_rejected_full),
    .out_shed_valid(out_shed_valid), .out_shed_tag(out_shed_tag),
    .out_replaced_valid(out_replaced_valid), .out_replaced_tag(out_replaced_tag),
    .out_popped_valid(out_popped_valid), .out_popped_tag(out_popped_tag),
    .out_popped_runs(out_popped_runs), .out_completions(out_completions),
    .out_queue_depth(out_queue_depth)
  );
endmodule
`default_nettype wire

[rtl/csjq_datapath.sv]
// csjq_datapath: slot store, compares, compaction and result registers
// depends on csjq_pkg
`default_nettype none
module csjq_datapath #(
  parameter int QUEUE_SLOTS = 16,
  parameter int TAG_BITS    = 16,
  parameter int KEY_BITS    = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire csjq_pkg::ctl_t      ctl,
  input  wire logic [2:0]          in_cmd,
  input  wire logic [TAG_BITS-1:0] in_job_tag,
  input  wire logic [KEY_BITS-1:0] in_key_id,
  input  wire logic                in_is_droppable,
  input  wire logic                in_cancel_first,
  input  wire logic                cfg_we,
  input  wire logic [4:0]          cfg_wdata,
  output logic                     out_accepted,
  output logic                     out_rejected_full,
  output logic                     out_shed_valid,
  output logic [TAG_BITS-1:0]      out_shed_tag,
  output logic                     out_replaced_valid,
  output logic [TAG_BITS-1:0]      out_replaced_tag,
  output logic                     out_popped_valid,
  output logic [TAG_BITS-1:0]      out_popped_tag,
  output logic                     out_popped_runs,
  output logic [1:0]               out_completions,
  output logic [4:0]               out_queue_depth
);
  localparam int IW = $clog2(QUEUE_SLOTS);
  localparam int CW = $clog2(QUEUE_SLOTS + 1);

  logic [TAG_BITS-1:0] tag_r [QUEUE_SLOTS];
  logic [KEY_BITS-1:0] key_r [QUEUE_SLOTS];
  logic [QUEUE_SLOTS-1:0] drp_r, cnc_r, arun_r, idx_r;
  logic [CW-1:0] cnt_r;
  logic stop_r;
  logic [4:0] budget_r;

  logic [2:0] cmd_r;
  logic [TAG_BITS-1:0] jtag_r;
  logic [KEY_BITS-1:0] jkey_r;
  logic jdrp_r, jcf_r;

  logic [1:0] comp_r;
  logic rpv_r, shv_r;
  logic [TAG_BITS-1:0] rpt_r, sht_r;

  logic is_post;
  assign is_post = cmd_r inside {csjq_pkg::CMD_POST_TAIL, csjq_pkg::CMD_POST_HEAD,
                                 csjq_pkg::CMD_POST_KEYED, csjq_pkg::CMD_BARRIER};

  // parallel compares and first-hit priority search
  logic [QUEUE_SLOTS-1:0] live, key_hit, shed_hit, hit_vec;
  logic [IW-1:0] hit_pos;
  logic hit_any;
  always_comb begin
    for (int i = 0; i < QUEUE_SLOTS; i++) begin
      live[i]     = (CW'(i) < cnt_r);
      key_hit[i]  = live[i] && idx_r[i] && (key_r[i] == jkey_r);
      shed_hit[i] = live[i] && drp_r[i] && !cnc_r[i];
    end
    hit_vec = ctl.replace ? key_hit : shed_hit;
    hit_pos = '0;
    hit_any = 1'b0;
    for (int i = QUEUE_SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_pos = IW'(i);
        hit_any = 1'b1;
      end
    end
  end

  logic shed_en;
  assign shed_en = (budget_r != 5'd0) && (int'(cnt_r) >= int'(budget_r));

  logic do_remove;
  logic [IW-1:0] rm_pos;
  logic full;
  assign full = (cnt_r == CW'(QUEUE_SLOTS));

  always_comb begin
    do_remove = 1'b0;
    rm_pos = hit_pos;
    if (ctl.replace && cmd_r == csjq_pkg::CMD_POST_KEYED && !stop_r && hit_any)
      do_remove = 1'b1;
    if (ctl.shed && !stop_r && is_post && cmd_r != csjq_pkg::CMD_BARRIER && shed_en && hit_any)
      do_remove = 1'b1;
    if (ctl.finish && cmd_r == csjq_pkg::CMD_POP && cnt_r != '0) begin
      do_remove = 1'b1;
      rm_pos = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      stop_r <= 1'b0;
      budget_r <= 5'd0;
      out_accepted <= 1'b0;
      out_rejected_full <= 1'b0;
      out_shed_valid <= 1'b0;
      out_replaced_valid <= 1'b0;
      out_popped_valid <= 1'b0;
      out_popped_runs <= 1'b0;
      out_completions <= 2'd0;
      out_queue_depth <= 5'd0;
      comp_r <= 2'd0;
      rpv_r <= 1'b0;
      shv_r <= 1'b0;
    end else begin
      if (cfg_we) budget_r <= cfg_wdata;
      if (ctl.capture) begin
        cmd_r <= in_cmd;
        jtag_r <= in_job_tag;
        jkey_r <= in_key_id;
        jdrp_r <= in_is_droppable;
        jcf_r <= in_cancel_first;
        comp_r <= 2'd0;
        rpv_r <= 1'b0;
        shv_r <= 1'b0;
        rpt_r <= '0;
        sht_r <= '0;
      end
      // compaction shift
      if (do_remove) begin
        for (int i = 0; i < QUEUE_SLOTS - 1; i++) begin
          if (IW'(i) >= rm_pos) begin
            tag_r[i] <= tag_r[i+1];
            key_r[i] <= key_r[i+1];
            drp_r[i] <= drp_r[i+1];
            cnc_r[i] <= cnc_r[i+1];
            arun_r[i] <= arun_r[i+1];
            idx_r[i] <= idx_r[i+1];
          end
        end
        cnt_r <= cnt_r - CW'(1);
        if (ctl.replace) begin
          rpv_r <= 1'b1;
          rpt_r <= tag_r[hit_pos];
          comp_r <= comp_r + 2'd1;
        end
        if (ctl.shed) begin
          shv_r <= 1'b1;
          sht_r <= tag_r[hit_pos];
          comp_r <= comp_r + 2'd1;
        end
      end
      if (ctl.shed && cmd_r == csjq_pkg::CMD_BARRIER && jcf_r && !stop_r) begin
        cnc_r <= '1;
        idx_r <= '0;
      end
      if (ctl.finish) begin
        out_accepted <= 1'b0;
        out_rejected_full <= 1'b0;
        out_shed_valid <= shv_r;
        out_shed_tag <= sht_r;
        out_replaced_valid <= rpv_r;
        out_replaced_tag <= rpt_r;
        out_popped_valid <= 1'b0;
        out_popped_tag <= '0;
        out_popped_runs <= 1'b0;
        out_completions <= comp_r;
        out_queue_depth <= 5'(cnt_r);
        case (cmd_r)
          csjq_pkg::CMD_CANCEL, csjq_pkg::CMD_SHUTDOWN: begin
            cnc_r <= '1;
            idx_r <= '0;
            if (cmd_r == csjq_pkg::CMD_SHUTDOWN) stop_r <= 1'b1;
          end
          csjq_pkg::CMD_POP: begin
            if (cnt_r != '0) begin
              out_popped_valid <= 1'b1;
              out_popped_tag <= tag_r[0];
              out_popped_runs <= !cnc_r[0] || arun_r[0];
              out_completions <= comp_r + 2'd1;
              out_queue_depth <= 5'(cnt_r - CW'(1));
            end
          end
          default: begin
            if (is_post && !stop_r) begin
              if (full) begin
                out_rejected_full <= 1'b1;
              end else begin
                out_accepted <= 1'b1;
                out_queue_depth <= 5'(cnt_r + CW'(1));
                cnt_r <= cnt_r + CW'(1);
                if (cmd_r == csjq_pkg::CMD_POST_HEAD) begin
                  for (int i = 1; i < QUEUE_SLOTS; i++) begin
                    tag_r[i] <= tag_r[i-1];
                    key_r[i] <= key_r[i-1];
                    drp_r[i] <= drp_r[i-1];
                    cnc_r[i] <= cnc_r[i-1];
                    arun_r[i] <= arun_r[i-1];
                    idx_r[i] <= idx_r[i-1];
                  end
                  tag_r[0] <= jtag_r;
                  key_r[0] <= jkey_r;
                  drp_r[0] <= 1'b0;
                  cnc_r[0] <= 1'b0;
                  arun_r[0] <= 1'b0;
                  idx_r[0] <= 1'b0;
                end else begin
                  tag_r[cnt_r[IW-1:0]] <= jtag_r;
                  key_r[cnt_r[IW-1:0]] <= jkey_r;
                  drp_r[cnt_r[IW-1:0]] <= jdrp_r && (cmd_r != csjq_pkg::CMD_BARRIER);
                  cnc_r[cnt_r[IW-1:0]] <= 1'b0;
                  arun_r[cnt_r[IW-1:0]] <= (cmd_r == csjq_pkg::CMD_BARRIER);
                  idx_r[cnt_r[IW-1:0]] <= (cmd_r == csjq_pkg::CMD_POST_KEYED);
                end
              end
            end
          end
        endcase
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_SLOTS)) else $error("count exceeds store");
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.capture, ctl.replace, ctl.shed, ctl.finish})) else $error("overlapping steps");
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |=> stop_r) else $error("stop flag cleared");
endmodule
`default_nettype wire

[rtl/csjq_ctrl.sv]
// csjq_ctrl: sequencer for capture, replace, shed and finish steps
// depends on csjq_pkg
`default_nettype none
module csjq_ctrl (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  output logic            out_valid,
  output csjq_pkg::ctl_t  ctl
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REPL = 3'd1;
  localparam logic [2:0] S_SHED = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;

  logic [2:0] state_r, state_nxt;
  logic done_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_REPL;
      S_REPL: state_nxt = S_SHED;
      S_SHED: state_nxt = S_FIN;
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign ctl.capture = (state_r == S_IDLE) && start;
  assign ctl.replace = (state_r == S_REPL);
  assign ctl.shed    = (state_r == S_SHED);
  assign ctl.finish  = (state_r == S_FIN);
  assign out_valid   = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r <= ctl.finish;
    end
  end

  a_fin_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish |=> out_valid) else $error("missing result strobe");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.replace |=> ctl.shed) else $error("step order broken");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.capture |=> busy) else $error("busy not raised");
endmodule
`default_nettype wire
